// ===== design/npp_pkg.sv =====
// Shared types, widths and codes for the nearest-point-on-polyline block.
package npp_pkg;

    localparam int COORD_BITS   = 24;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIFF_BITS;
    localparam int SUM_BITS     = PROD_BITS + 1;
    localparam int DIST_BITS    = 2 * COORD_BITS + 4;
    localparam int QUO_BITS     = COORD_BITS + 1;
    localparam int CNT_BITS     = $clog2(COORD_BITS);
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_QUERY_X = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUERY_Y = 1'b1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic                         first_vertex;
        logic                         last_vertex;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] nearest_x;
        logic signed [COORD_BITS-1:0] nearest_y;
        logic                         found;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic delta;
        logic mul_len;
        logic mul_dot;
        logic sum_dot;
        logic decide;
        logic div_step;
        logic round;
        logic err;
        logic mul_err;
        logic cmp;
        logic finish;
    } t_npp_cmd;

    typedef struct packed {
        logic seg;
        logic need_div;
        logic last;
        logic out_free;
    } t_npp_status;

endpackage

// ===== design/npp_ctrl.sv =====
// Sequencer that steps the datapath through one vertex.
module npp_ctrl import npp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_npp_status i_status,
    output logic        o_in_ready,
    output t_npp_cmd    o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_DELTA  = 12'b000000000010,
        S_LEN    = 12'b000000000100,
        S_DOT    = 12'b000000001000,
        S_SUMDOT = 12'b000000010000,
        S_DECIDE = 12'b000000100000,
        S_DIV    = 12'b000001000000,
        S_ROUND  = 12'b000010000000,
        S_ERR    = 12'b000100000000,
        S_DIST   = 12'b001000000000,
        S_CMP    = 12'b010000000000,
        S_FINISH = 12'b100000000000
    } t_state;

    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(COORD_BITS - 1);

    t_state              r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DELTA;
                end
            end
            S_DELTA: begin
                if (i_status.seg) begin
                    o_cmd.delta = 1'b1;
                    n_state     = S_LEN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_LEN: begin
                o_cmd.mul_len = 1'b1;
                n_state       = S_DOT;
            end
            S_DOT: begin
                o_cmd.mul_dot = 1'b1;
                n_state       = S_SUMDOT;
            end
            S_SUMDOT: begin
                o_cmd.sum_dot = 1'b1;
                n_state       = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_cnt        = '0;
                n_state      = i_status.need_div ? S_DIV : S_ERR;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_ROUND;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_ERR;
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_state   = S_DIST;
            end
            S_DIST: begin
                o_cmd.mul_err = 1'b1;
                n_state       = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                // A last word has to wait until the output register is free.
                if (!i_status.last || i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== design/npp_dpath.sv =====
// Datapath: segment projection, serial scaling divider, best tracking, output register.
module npp_dpath import npp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COORD_BITS-1:0]   i_cfg_data,
    input  t_in_word                i_in_word,
    input  logic                    i_out_ready,
    input  t_npp_cmd                i_cmd,
    output t_npp_status             o_status,
    output logic                    o_out_valid,
    output t_out_word               o_out_word
);

    localparam int RW = SUM_BITS;

    typedef struct packed {
        logic [RW-1:0]       rem;
        logic [QUO_BITS-1:0] quo;
    } t_div;

    // One bit of |delta| * dot / len_sq: the partial remainder can reach
    // up to three times the divisor, so the quotient grows by 0, 1 or 2.
    function automatic t_div div_step(input logic [RW-1:0] r, input logic [QUO_BITS-1:0] q,
                                      input logic b, input logic [RW-1:0] num,
                                      input logic [RW-1:0] den);
        logic [RW-1:0]       r2;
        logic [RW-1:0]       den2;
        logic [QUO_BITS-1:0] q2;
        t_div                res;
        r2   = {r[RW-2:0], 1'b0} + (b ? num : '0);
        den2 = {den[RW-2:0], 1'b0};
        q2   = {q[QUO_BITS-2:0], 1'b0};
        if (r2 >= den2) begin
            res.rem = r2 - den2;
            res.quo = q2 + QUO_BITS'(2);
        end else if (r2 >= den) begin
            res.rem = r2 - den;
            res.quo = q2 + QUO_BITS'(1);
        end else begin
            res.rem = r2;
            res.quo = q2;
        end
        return res;
    endfunction

    logic signed [COORD_BITS-1:0] r_query_x, r_query_y;
    logic signed [COORD_BITS-1:0] r_vx, r_vy, r_prev_x, r_prev_y;
    logic                         r_have_prev, r_seg, r_last;
    logic        [DIST_BITS-1:0]  r_best_d;
    logic signed [COORD_BITS-1:0] r_best_x, r_best_y;
    logic                         r_best_valid;
    logic signed [DIFF_BITS-1:0]  r_dx, r_dy, r_wx, r_wy;
    logic signed [PROD_BITS-1:0]  r_p0, r_p1;
    logic signed [SUM_BITS-1:0]   r_len, r_dot;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic        [COORD_BITS-1:0] r_mx, r_my;
    logic        [RW-1:0]         r_rx, r_ry;
    logic        [QUO_BITS-1:0]   r_qx, r_qy;
    logic                         r_out_valid;
    t_out_word                    r_out_word;

    logic signed [DIFF_BITS-1:0]  m0_a, m0_b, m1_a, m1_b;
    logic signed [SUM_BITS-1:0]   psum;
    logic                         len_zero, dot_neg, dot_over, need_div;
    logic signed [DIFF_BITS-1:0]  abs_dx, abs_dy;
    logic        [RW-1:0]         u_dot, u_len;
    t_div                         step_x, step_y;
    logic                         rnd_x, rnd_y;
    logic        [QUO_BITS-1:0]   off_x, off_y;
    logic signed [DIFF_BITS-1:0]  sum_x, sum_y;
    logic        [DIST_BITS-1:0]  d2;

    // Shared multiplier pair: segment length, then dot product, then error.
    // The error terms reuse the query-offset registers.
    assign m0_a = i_cmd.mul_len ? r_dx : r_wx;
    assign m0_b = i_cmd.mul_err ? r_wx : r_dx;
    assign m1_a = i_cmd.mul_len ? r_dy : r_wy;
    assign m1_b = i_cmd.mul_err ? r_wy : r_dy;
    assign psum = SUM_BITS'(r_p0) + SUM_BITS'(r_p1);

    assign len_zero = (r_len == '0);
    assign dot_neg  = r_dot[SUM_BITS-1];
    assign dot_over = (r_dot > r_len);
    assign need_div = !len_zero && !dot_neg && !dot_over;

    assign abs_dx = r_dx[DIFF_BITS-1] ? -r_dx : r_dx;
    assign abs_dy = r_dy[DIFF_BITS-1] ? -r_dy : r_dy;
    assign u_dot  = $unsigned(r_dot);
    assign u_len  = $unsigned(r_len);

    assign step_x = div_step(r_rx, r_qx, r_mx[COORD_BITS-1], u_dot, u_len);
    assign step_y = div_step(r_ry, r_qy, r_my[COORD_BITS-1], u_dot, u_len);

    // Round half away from zero on the magnitude, then apply the sign of delta.
    assign rnd_x = ({r_rx[RW-2:0], 1'b0} >= u_len);
    assign rnd_y = ({r_ry[RW-2:0], 1'b0} >= u_len);
    assign off_x = r_qx + QUO_BITS'(rnd_x);
    assign off_y = r_qy + QUO_BITS'(rnd_y);
    assign sum_x = r_dx[DIFF_BITS-1] ? DIFF_BITS'(r_prev_x) - $signed(off_x)
                                     : DIFF_BITS'(r_prev_x) + $signed(off_x);
    assign sum_y = r_dy[DIFF_BITS-1] ? DIFF_BITS'(r_prev_y) - $signed(off_y)
                                     : DIFF_BITS'(r_prev_y) + $signed(off_y);

    assign d2 = DIST_BITS'($unsigned(psum));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_x <= '0;
            r_query_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_QUERY_X: r_query_x <= $signed(i_cfg_data);
                CFG_QUERY_Y: r_query_y <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Polyline state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev  <= 1'b0;
            r_seg        <= 1'b0;
            r_last       <= 1'b0;
            r_best_d     <= '1;
            r_best_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load) begin
                r_last <= i_in_word.last_vertex;
                r_seg  <= r_have_prev && !i_in_word.first_vertex;
                if (i_in_word.first_vertex) begin
                    r_have_prev  <= 1'b0;
                    r_best_d     <= '1;
                    r_best_valid <= 1'b0;
                end
            end
            if (i_cmd.cmp && (d2 < r_best_d)) begin
                r_best_d     <= d2;
                r_best_valid <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_have_prev <= !r_last;
                if (r_last) begin
                    r_out_valid  <= 1'b1;
                    r_best_d     <= '1;
                    r_best_valid <= 1'b0;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_vx <= i_in_word.vertex_x;
            r_vy <= i_in_word.vertex_y;
        end
        if (i_cmd.delta) begin
            r_dx <= DIFF_BITS'(r_vx) - DIFF_BITS'(r_prev_x);
            r_dy <= DIFF_BITS'(r_vy) - DIFF_BITS'(r_prev_y);
            r_wx <= DIFF_BITS'(r_query_x) - DIFF_BITS'(r_prev_x);
            r_wy <= DIFF_BITS'(r_query_y) - DIFF_BITS'(r_prev_y);
        end
        if (i_cmd.mul_len || i_cmd.mul_dot || i_cmd.mul_err) begin
            r_p0 <= m0_a * m0_b;
            r_p1 <= m1_a * m1_b;
        end
        if (i_cmd.mul_dot) begin
            r_len <= psum;
        end
        if (i_cmd.sum_dot) begin
            r_dot <= psum;
        end
        if (i_cmd.decide) begin
            r_px <= (!len_zero && !dot_neg && dot_over) ? r_vx : r_prev_x;
            r_py <= (!len_zero && !dot_neg && dot_over) ? r_vy : r_prev_y;
            r_mx <= abs_dx[COORD_BITS-1:0];
            r_my <= abs_dy[COORD_BITS-1:0];
            r_rx <= '0;
            r_ry <= '0;
            r_qx <= '0;
            r_qy <= '0;
        end
        if (i_cmd.div_step) begin
            r_mx <= {r_mx[COORD_BITS-2:0], 1'b0};
            r_my <= {r_my[COORD_BITS-2:0], 1'b0};
            r_rx <= step_x.rem;
            r_ry <= step_y.rem;
            r_qx <= step_x.quo;
            r_qy <= step_y.quo;
        end
        if (i_cmd.round) begin
            r_px <= $signed(sum_x[COORD_BITS-1:0]);
            r_py <= $signed(sum_y[COORD_BITS-1:0]);
        end
        if (i_cmd.err) begin
            r_wx <= DIFF_BITS'(r_query_x) - DIFF_BITS'(r_px);
            r_wy <= DIFF_BITS'(r_query_y) - DIFF_BITS'(r_py);
        end
        if (i_cmd.cmp && (d2 < r_best_d)) begin
            r_best_x <= r_px;
            r_best_y <= r_py;
        end
        if (i_cmd.finish) begin
            r_prev_x <= r_vx;
            r_prev_y <= r_vy;
            if (r_last) begin
                r_out_word.nearest_x <= r_best_valid ? r_best_x : '0;
                r_out_word.nearest_y <= r_best_valid ? r_best_y : '0;
                r_out_word.found     <= r_best_valid;
            end
        end
    end

    assign o_status.seg      = r_seg;
    assign o_status.need_div = need_div;
    assign o_status.last     = r_last;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out_word;

endmodule

// ===== design/nearest_point_on_polyline_unit.sv =====
// Top level of the nearest-point-on-polyline block.
// Vertices arrive one word at a time; each vertex after the first closes a
// segment, the query point (query_x, query_y) is projected onto it with the
// projection clamped to the segment ends, and the projection nearest to the
// query is kept, the earliest winning a tie. A word flagged last_vertex
// produces one result word (nearest point and found flag) in an output
// register, so the next vertex can be taken while that result waits. A word
// that forms no segment goes straight to its finish step; when the projection
// is clamped or the segment has zero length the divider is skipped; otherwise
// the scaling divider forms |delta| * dot / len_sq for x and y side by side,
// one bit of |delta| per cycle. The query registers must be written only
// while the block is idle.
module nearest_point_on_polyline_unit import npp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COORD_BITS-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in_word                i_in_word,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out_word               o_out_word
);

    t_npp_cmd    cmd;
    t_npp_status status;

    npp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    npp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule
